// ----- rtl/djb2_pkg.sv -----
// Package: shared types, constants and codes of the djb2 hash table engine.
package djb2_pkg;
    localparam int NUM_BUCKETS = 64;
    localparam int WAYS        = 8;
    localparam int SLOT_COUNT  = NUM_BUCKETS * WAYS;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int HASH_W      = 64;
    localparam int REM_W       = 7;
    localparam int CNT_W       = 13;
    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
    localparam logic [6:0] BUCKETS_MAX = 7'(NUM_BUCKETS);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_GET    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  key_byte;
        logic        key_last;
        logic [31:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [12:0] stored_count;
    } out_beat_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

// ----- rtl/djb2_mod_unit.sv -----
// Restoring bit-serial remainder of a 64-bit hash by the bucket count.
module djb2_mod_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [djb2_pkg::HASH_W-1:0]  dividend,
    input  logic [6:0]                   divisor,
    output djb2_pkg::div_ctl_t           ctl,
    output logic [djb2_pkg::REM_W-1:0]   remainder
);
    import djb2_pkg::*;

    logic [HASH_W-1:0] shift_reg;
    logic [REM_W:0]    rem_reg;
    logic [6:0]        bit_cnt_reg;
    logic              busy_reg, done_reg;
    logic [REM_W:0]    trial;

    always_comb begin
        trial = {rem_reg[REM_W-1:0], shift_reg[HASH_W-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= '0;
                shift_reg   <= dividend;
                rem_reg     <= '0;
            end else if (busy_reg) begin
                shift_reg <= {shift_reg[HASH_W-2:0], 1'b0};
                if (trial >= {1'b0, divisor}) rem_reg <= trial - {1'b0, divisor};
                else rem_reg <= trial;
                bit_cnt_reg <= bit_cnt_reg + 7'd1;
                if (bit_cnt_reg == 7'(HASH_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign ctl       = '{start: start, busy: busy_reg, done: done_reg};
    assign remainder = rem_reg[REM_W-1:0];
endmodule

// ----- rtl/djb2_hash_table_engine_unit.sv -----
// Top level: djb2 hash table engine with a shared serial modulo unit and way scan.
// A key byte without key_last is folded into the running hash as it is taken
// (hash*33 is a shift and add). A last byte folds in, then the hash goes through a
// bit-serial remainder unit, then the bucket's WAYS slots are read one at a time
// from the slot memory (each read, then compared), then an action step and an
// output step raise the result. Clear replaces the scan with a sweep over the slot
// valid bits, one per cycle, and then presents its beat. No input beat is taken
// while a result waits. After reset a clearing pass empties the table before the
// first beat is taken; bucket count writes are taken throughout.
module djb2_hash_table_engine_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  djb2_pkg::in_beat_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output djb2_pkg::out_beat_t   m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [6:0]            cfg_data
);
    import djb2_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_ACT   = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]        state_reg;
    logic [HASH_W-1:0] hash_reg, key_hash_reg;
    logic [6:0]        bcount_reg, eff_bcount;
    logic [1:0]        act_reg;
    logic [31:0]       val_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [SLOT_W-1:0] base_reg, sweep_reg;
    logic [WAY_W:0]    way_reg;
    logic              hit_reg, free_seen_reg;
    logic [WAY_W-1:0]  hit_way_reg, free_way_reg;
    logic              slot_valid_reg [SLOT_COUNT];
    logic [HASH_W-1:0] slot_hash_mem [SLOT_COUNT];
    logic [31:0]       slot_value_mem [SLOT_COUNT];
    logic [HASH_W-1:0] rd_hash_reg;
    logic [31:0]       rd_value_reg, hit_value_reg;
    logic              rd_valid_reg;
    out_beat_t         out_reg;
    logic              out_valid_reg;
    logic              rst_pass_reg;
    div_ctl_t          div_ctl;
    logic [REM_W-1:0]  rem;
    logic              div_start;
    logic [HASH_W-1:0] hash_next;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_addr;

    // Clamp the bucket count into 1..NUM_BUCKETS.
    always_comb begin
        eff_bcount = bcount_reg;
        if (eff_bcount == 7'd0) eff_bcount = 7'd1;
        if (eff_bcount > BUCKETS_MAX) eff_bcount = BUCKETS_MAX;
    end

    // djb2 step: hash*33 + byte; a zero byte leaves the hash alone.
    always_comb begin
        hash_next = hash_reg;
        if (s_data.key_byte != 8'd0)
            hash_next = (hash_reg << 5) + hash_reg + {56'd0, s_data.key_byte};
    end

    assign s_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign div_start = s_valid && s_ready && s_data.key_last;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign rd_addr   = base_reg + SLOT_W'(way_reg[WAY_W-1:0]);

    djb2_mod_unit u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(hash_next),
        .divisor(eff_bcount), .ctl(div_ctl), .remainder(rem)
    );

    // Slot memories: one read port with registered data, one write port.
    always_ff @(posedge aclk) begin
        rd_hash_reg  <= slot_hash_mem[rd_addr];
        rd_value_reg <= slot_value_mem[rd_addr];
        rd_valid_reg <= slot_valid_reg[rd_addr];
        if (state_reg == S_ACT && act_reg == ACT_INSERT && !hit_reg && free_seen_reg) begin
            slot_hash_mem[wr_addr]  <= key_hash_reg;
            slot_value_mem[wr_addr] <= val_reg;
        end
    end

    assign wr_addr = base_reg + SLOT_W'(free_way_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            sweep_reg     <= '0;
            hash_reg      <= HASH_SEED;
            bcount_reg    <= 7'd64;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            act_reg       <= ACT_CLEAR;
        end else begin
            if (cfg_valid && cfg_ready) bcount_reg <= cfg_data;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        if (s_data.key_last) begin
                            hash_reg     <= HASH_SEED;
                            key_hash_reg <= hash_next;
                            act_reg      <= s_data.action;
                            val_reg      <= s_data.value;
                            state_reg    <= S_MOD;
                        end else begin
                            hash_reg <= hash_next;
                        end
                    end
                end
                S_MOD: begin
                    if (div_ctl.done) begin
                        base_reg      <= SLOT_W'(rem) * SLOT_W'(WAYS);
                        way_reg       <= '0;
                        hit_reg       <= 1'b0;
                        free_seen_reg <= 1'b0;
                        sweep_reg     <= '0;
                        state_reg     <= (act_reg == ACT_CLEAR) ? S_SWEEP : S_READ;
                    end
                end
                S_READ: state_reg <= S_CMP;
                S_CMP: begin
                    // Scan ways in order: first match, first free slot.
                    if (rd_valid_reg && rd_hash_reg == key_hash_reg && !hit_reg) begin
                        hit_reg       <= 1'b1;
                        hit_way_reg   <= way_reg[WAY_W-1:0];
                        hit_value_reg <= rd_value_reg;
                    end
                    if (!rd_valid_reg && !free_seen_reg) begin
                        free_seen_reg <= 1'b1;
                        free_way_reg  <= way_reg[WAY_W-1:0];
                    end
                    if (way_reg == (WAY_W+1)'(WAYS - 1)) state_reg <= S_ACT;
                    else begin
                        way_reg   <= way_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_ACT: begin
                    if (act_reg == ACT_INSERT) begin
                        if (hit_reg) begin
                            out_reg <= '{status: ST_PRESENT, found_value: 32'd0,
                                         stored_count: total_reg};
                        end else if (!free_seen_reg) begin
                            out_reg <= '{status: ST_FULL, found_value: 32'd0,
                                         stored_count: total_reg};
                        end else begin
                            slot_valid_reg[wr_addr] <= 1'b1;
                            total_reg <= total_reg + 13'd1;
                            out_reg   <= '{status: ST_DONE, found_value: 32'd0,
                                           stored_count: total_reg + 13'd1};
                        end
                    end else if (!hit_reg) begin
                        out_reg <= '{status: ST_ABSENT, found_value: 32'd0,
                                     stored_count: total_reg};
                    end else if (act_reg == ACT_REMOVE) begin
                        slot_valid_reg[base_reg + SLOT_W'(hit_way_reg)] <= 1'b0;
                        if (total_reg != '0) begin
                            total_reg <= total_reg - 13'd1;
                            out_reg   <= '{status: ST_DONE, found_value: hit_value_reg,
                                           stored_count: total_reg - 13'd1};
                        end else begin
                            out_reg <= '{status: ST_DONE, found_value: hit_value_reg,
                                         stored_count: total_reg};
                        end
                    end else begin
                        out_reg <= '{status: ST_DONE, found_value: hit_value_reg,
                                     stored_count: total_reg};
                    end
                    state_reg <= S_OUT;
                end
                S_SWEEP: begin
                    slot_valid_reg[sweep_reg] <= 1'b0;
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == SLOT_W'(SLOT_COUNT - 1)) begin
                        total_reg <= '0;
                        out_reg   <= '{status: ST_DONE, found_value: 32'd0,
                                       stored_count: '0};
                        // The reset pass produces no beat.
                        state_reg <= (act_reg == ACT_CLEAR && !rst_pass_reg) ? S_OUT : S_IDLE;
                    end
                end
                S_OUT: begin
                    out_valid_reg <= 1'b1;
                    act_reg       <= ACT_GET;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Mark the reset clearing pass so that it delivers no beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) rst_pass_reg <= 1'b1;
        else if (state_reg == S_SWEEP && sweep_reg == SLOT_W'(SLOT_COUNT - 1))
            rst_pass_reg <= 1'b0;
    end

    // No input beat is taken while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    // The modulo unit only runs while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctl.busy |-> state_reg == S_MOD) else $error("divider busy outside MOD");
    // A result rises only after the action step or a sweep.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == S_OUT) else $error("stray result");
endmodule

// ----- tb/djb2_hash_table_engine_unit_tb.sv -----
// Testbench for the djb2 hash table engine: directed and random key streams checked against a table model.
module djb2_hash_table_engine_unit_tb;
    import djb2_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 700;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_beat_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_beat_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;

    djb2_hash_table_engine_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Table model: own copy of the hash, slots, count and bucket register.
    logic [63:0] run_hash;
    logic        tbl_valid [SLOT_COUNT];
    logic [63:0] tbl_hash  [SLOT_COUNT];
    logic [31:0] tbl_value [SLOT_COUNT];
    logic [12:0] tbl_count;
    logic [6:0]  tbl_buckets;

    in_beat_t  key_beats [$];   // beats waiting for the driver
    out_beat_t want_q    [$];   // results expected from the block

    int  mismatches;
    int  idle_pct_s;
    int  idle_pct_m;
    int  quiet_cycles;
    bit  timed_out;
    bit  drive_hold;
    bit  s_acc;                 // input beat taken at the last rising edge

    // Fold one accepted beat into the model; queue an expected result on the last byte.
    function automatic void model_beat(input in_beat_t b);
        logic [63:0] h;
        int          nb, base, hit, w;
        out_beat_t   r;
        if (b.key_byte != 8'd0)
            run_hash = run_hash * 64'd33 + 64'(b.key_byte);
        if (!b.key_last)
            return;
        h        = run_hash;
        run_hash = HASH_SEED;
        nb = (tbl_buckets == 7'd0) ? 1 :
             (tbl_buckets > BUCKETS_MAX) ? NUM_BUCKETS : int'(tbl_buckets);
        base = int'(h % 64'(nb)) * WAYS;
        r.status      = ST_DONE;
        r.found_value = '0;
        if (b.action == ACT_CLEAR) begin
            for (int i = 0; i < SLOT_COUNT; i++)
                tbl_valid[i] = 1'b0;
            tbl_count = '0;
        end else begin
            hit = -1;
            for (w = 0; w < WAYS; w++)
                if (hit < 0 && tbl_valid[base+w] && tbl_hash[base+w] == h)
                    hit = base + w;
            if (b.action == ACT_INSERT) begin
                if (hit >= 0) begin
                    r.status = ST_PRESENT;
                end else begin
                    r.status = ST_FULL;
                    for (w = 0; w < WAYS; w++) begin
                        if (r.status == ST_FULL && !tbl_valid[base+w]) begin
                            tbl_valid[base+w] = 1'b1;
                            tbl_hash[base+w]  = h;
                            tbl_value[base+w] = b.value;
                            tbl_count++;
                            r.status = ST_DONE;
                        end
                    end
                end
            end else if (hit < 0) begin
                r.status = ST_ABSENT;
            end else begin
                r.found_value = tbl_value[hit];
                if (b.action == ACT_REMOVE) begin
                    tbl_valid[hit] = 1'b0;
                    if (tbl_count != 0)
                        tbl_count--;
                end
            end
        end
        r.stored_count = tbl_count;
        want_q.push_back(r);
    endfunction

    // Queue one key: len bytes drawn mostly from a small alphabet so keys repeat.
    task automatic push_key(input logic [1:0] act, input int len, input logic [31:0] val);
        in_beat_t b;
        for (int i = 0; i < len; i++) begin
            b.action   = 2'($urandom);
            b.key_byte = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                         8'($urandom_range(8'h61, 8'h64));
            b.key_last = (i == len - 1);
            b.value    = $urandom;
            if (b.key_last) begin
                b.action = act;
                b.value  = val;
            end
            key_beats.push_back(b);
        end
    endtask

    task automatic push_raw(input logic [1:0] act, input logic [7:0] kb,
                            input logic last, input logic [31:0] val);
        in_beat_t b;
        b.action   = act;
        b.key_byte = kb;
        b.key_last = last;
        b.value    = val;
        key_beats.push_back(b);
    endtask

    // Hold until the driver has emptied its queue and every result has come.
    task automatic wait_idle();
        while (key_beats.size() != 0 || s_valid || want_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write the bucket register and update the model's copy.
    task automatic write_buckets(input logic [6:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tbl_buckets = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Driver: present the head of the queue, idling at random between beats.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_acc) begin
            // hold the beat until accepted
        end else if (key_beats.size() != 0 && !drive_hold &&
                     $urandom_range(0, 99) >= idle_pct_s) begin
            s_valid <= 1'b1;
            s_data  <= key_beats.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
        m_ready <= ($urandom_range(0, 99) >= idle_pct_m);
    end

    // Monitor: model accepted beats, check results, run the watchdog.
    always @(posedge aclk) begin
        s_acc = s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                model_beat(s_data);
            if (m_valid && m_ready) begin
                if (want_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d found %h count %0d",
                                 m_data.status, m_data.found_value, m_data.stored_count);
                end else if (m_data !== want_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st %0d val %h cnt %0d, got st %0d val %h cnt %0d",
                                 want_q[0].status, want_q[0].found_value,
                                 want_q[0].stored_count, m_data.status,
                                 m_data.found_value, m_data.stored_count);
                    void'(want_q.pop_front());
                end else begin
                    void'(want_q.pop_front());
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("djb2_hash_table_engine_unit_tb failed");
                $finish;
            end
        end
    end

    initial begin
        logic [6:0] bsel [6];
        bsel = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd17};
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 7'd64;
        mismatches = 0;
        quiet_cycles = 0;
        timed_out  = 1'b0;
        drive_hold = 1'b0;
        s_acc      = 1'b0;
        idle_pct_s = 0;
        idle_pct_m = 0;
        run_hash   = HASH_SEED;
        tbl_count  = '0;
        tbl_buckets = 7'd64;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_hash[i]  = '0;
            tbl_value[i] = '0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: field extremes, every action, duplicate, missing and full bucket.
        write_buckets(7'd1);
        push_raw(ACT_INSERT, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        push_raw(ACT_INSERT, 8'hFF, 1'b1, 32'h0);          // already present
        push_raw(ACT_GET,    8'hFF, 1'b1, 32'h0);
        push_raw(ACT_GET,    8'h00, 1'b1, 32'h0);          // zero byte: seed key, absent
        push_raw(ACT_CLEAR,  8'h00, 1'b0, 32'hFFFF_FFFF);  // action ignored mid-key
        push_raw(ACT_REMOVE, 8'hFF, 1'b1, 32'h0);          // zero then FF: same key
        push_raw(ACT_REMOVE, 8'hFF, 1'b1, 32'h0);          // now absent
        for (int i = 1; i <= 9; i++)                       // ninth overflows the bucket
            push_raw(ACT_INSERT, 8'(i), 1'b1, 32'(i * 111));
        push_raw(ACT_CLEAR,  8'h55, 1'b1, 32'h0);
        push_raw(ACT_GET,    8'h01, 1'b1, 32'h0);
        wait_idle();

        // Random phases across bucket settings; entries survive a change.
        for (int ph = 0; ph < 6; ph++) begin
            write_buckets(bsel[ph]);
            idle_pct_s = (ph == 2) ? 0 : 28;
            idle_pct_m = (ph == 2) ? 0 : 28;
            for (int k = 0; k < 36; k++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 40)      push_key(ACT_INSERT, $urandom_range(1, 3), $urandom);
                else if (r < 70) push_key(ACT_GET,    $urandom_range(1, 3), $urandom);
                else if (r < 95) push_key(ACT_REMOVE, $urandom_range(1, 3), $urandom);
                else             push_key(ACT_CLEAR,  $urandom_range(1, 2), $urandom);
            end
            if (ph == 3) begin
                // pause the sender until the block has answered everything
                while (key_beats.size() > 40) @(posedge aclk);
                drive_hold = 1'b1;
                while (s_valid || want_q.size() != 0) @(posedge aclk);
                drive_hold = 1'b0;
            end
            wait_idle();
        end

        wait_idle();
        if (mismatches == 0 && want_q.size() == 0)
            $display("djb2_hash_table_engine_unit_tb passed");
        else
            $display("djb2_hash_table_engine_unit_tb failed");
        $finish;
    end
endmodule
